// File: hdl/nnr_pkg.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor resize package
// Shared widths, register map, state encoding and the size clamp helper.
// ----------------------------------------------------------------------------
package nnr_pkg;

	// Field widths of the request and response beats.
	localparam int unsigned COORD_W = 10;
	localparam int unsigned CH_W    = 2;
	localparam int unsigned PIX_W   = 8;

	// Configuration register widths.
	localparam int unsigned SRC_W = 7;
	localparam int unsigned CHN_W = 3;
	localparam int unsigned DST_W = 11;

	// Configuration port.
	localparam int unsigned APB_AW = 5;
	localparam int unsigned APB_DW = 32;

	// Register reset values.
	localparam logic [SRC_W-1:0] SRC_ROWS_RST = SRC_W'(64);
	localparam logic [SRC_W-1:0] SRC_COLS_RST = SRC_W'(64);
	localparam logic [CHN_W-1:0] CHANNELS_RST = CHN_W'(3);
	localparam logic [DST_W-1:0] DST_ROWS_RST = DST_W'(64);
	localparam logic [DST_W-1:0] DST_COLS_RST = DST_W'(64);

	// Default capacity of the pixel store and the destination limit.
	localparam int unsigned MAX_ROWS_DEF     = 64;
	localparam int unsigned MAX_COLS_DEF     = 64;
	localparam int unsigned MAX_CHANNELS_DEF = 4;
	localparam int unsigned MAX_DST_DEF      = 1024;

	// Divider widths. The mapped index never exceeds the source size minus
	// one, so the quotient fits in the source register width.
	localparam int unsigned QUO_W = SRC_W;
	localparam int unsigned DEN_W = DST_W + 1;
	localparam int unsigned DSR_W = DEN_W + QUO_W - 1;
	localparam int unsigned NUM_W = DSR_W + 1;
	localparam int unsigned CNT_W = $clog2(QUO_W);

	// Register index, taken from paddr[4:2].
	typedef enum logic [2:0] {
		REG_SRC_ROWS = 3'd0,
		REG_SRC_COLS = 3'd1,
		REG_CHANNELS = 3'd2,
		REG_DST_ROWS = 3'd3,
		REG_DST_COLS = 3'd4
	} reg_idx_t;

	// Request kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// Response status codes.
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	// Size register taken into its legal range: zero acts as one, anything
	// above the limit acts as the limit.
	function automatic logic [DST_W-1:0] clamp_size(logic [DST_W-1:0] v, int unsigned hi);
		logic [DST_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DST_W'(1);
		end else if (32'(v) > hi) begin
			r = DST_W'(hi);
		end
		return r;
	endfunction

endpackage

// File: hdl/nnr_req_if.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor resize request channel
// Valid/ready channel that carries one write or read request per beat.
// ----------------------------------------------------------------------------
interface nnr_req_if;

	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [nnr_pkg::COORD_W-1:0]  row;
	logic [nnr_pkg::COORD_W-1:0]  col;
	logic [nnr_pkg::CH_W-1:0]     channel;
	logic [nnr_pkg::PIX_W-1:0]    pixel_in;

	modport source (output valid, kind, row, col, channel, pixel_in, input ready);
	modport sink   (input valid, kind, row, col, channel, pixel_in, output ready);

endinterface

// File: hdl/nnr_rsp_if.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor resize response channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
interface nnr_rsp_if;

	logic                      valid;
	logic                      ready;
	logic [nnr_pkg::PIX_W-1:0] pixel_out;
	logic                      status;

	modport source (output valid, pixel_out, status, input ready);
	modport sink   (input valid, pixel_out, status, output ready);

endinterface

// File: hdl/nnr_div.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor resize divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [nnr_pkg::NUM_W-1:0]  num,
	input  logic [nnr_pkg::DEN_W-1:0]  den,
	output logic [nnr_pkg::QUO_W-1:0]  quo,
	output logic                       busy
);

	logic                       busy_q;
	logic [nnr_pkg::CNT_W-1:0]  cnt_q;
	logic [nnr_pkg::NUM_W-1:0]  rem_q;
	logic [nnr_pkg::DSR_W-1:0]  dsr_q;
	logic [nnr_pkg::QUO_W-1:0]  quo_q;
	logic                       fits;

	// The shifted divisor fits into the partial remainder.
	assign fits = ({1'b0, dsr_q} <= rem_q);

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + nnr_pkg::CNT_W'(1);
			if (cnt_q == nnr_pkg::CNT_W'(nnr_pkg::QUO_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder, divisor and quotient datapath. The caller guarantees the
	// quotient fits in QUO_W bits, so the divisor starts shifted by QUO_W-1.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsr_q <= {den, {(nnr_pkg::QUO_W - 1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - {1'b0, dsr_q};
			end
			quo_q <= {quo_q[nnr_pkg::QUO_W-2:0], fits};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign quo  = quo_q;
	assign busy = busy_q;

endmodule

// File: hdl/nearest_neighbor_resize_top.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor resize, aligned corners
// Pixel store with write requests and resized read requests.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A write request passes through the
// accept state, a state that checks the range and writes the store, and one
// that loads the output register. A read request passes through the accept
// state, a range check, the two radix-2 dividers that map the row and the
// column in parallel at one quotient bit per cycle, one read of the
// single-port pixel store and the load of the output register; a read that
// fails the range check skips the dividers and the store read.
// The result beat sits in an output register, so the block returns to
// accepting requests while it waits to be taken; a new result is held back
// only while the previous one is still unclaimed. The pixel store is not
// cleared after reset: reading a sample that was never written returns an
// arbitrary value.
module nearest_neighbor_resize_top #(
	parameter int unsigned MAX_ROWS     = nnr_pkg::MAX_ROWS_DEF,
	parameter int unsigned MAX_COLS     = nnr_pkg::MAX_COLS_DEF,
	parameter int unsigned MAX_CHANNELS = nnr_pkg::MAX_CHANNELS_DEF,
	parameter int unsigned MAX_DST      = nnr_pkg::MAX_DST_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	nnr_req_if.sink                     req,
	nnr_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nnr_pkg::APB_AW-1:0]  paddr,
	input  logic [nnr_pkg::APB_DW-1:0]  pwdata,
	output logic [nnr_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS * MAX_CHANNELS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned ROW_STRIDE = MAX_COLS * MAX_CHANNELS;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [nnr_pkg::SRC_W-1:0] src_rows_q;
	logic [nnr_pkg::SRC_W-1:0] src_cols_q;
	logic [nnr_pkg::CHN_W-1:0] channels_q;
	logic [nnr_pkg::DST_W-1:0] dst_rows_q;
	logic [nnr_pkg::DST_W-1:0] dst_cols_q;
	logic                      cfg_we;
	nnr_pkg::reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = nnr_pkg::reg_idx_t'(paddr[4:2]);

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_rows_q <= nnr_pkg::SRC_ROWS_RST;
			src_cols_q <= nnr_pkg::SRC_COLS_RST;
			channels_q <= nnr_pkg::CHANNELS_RST;
			dst_rows_q <= nnr_pkg::DST_ROWS_RST;
			dst_cols_q <= nnr_pkg::DST_COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				nnr_pkg::REG_SRC_ROWS: src_rows_q <= pwdata[nnr_pkg::SRC_W-1:0];
				nnr_pkg::REG_SRC_COLS: src_cols_q <= pwdata[nnr_pkg::SRC_W-1:0];
				nnr_pkg::REG_CHANNELS: channels_q <= pwdata[nnr_pkg::CHN_W-1:0];
				nnr_pkg::REG_DST_ROWS: dst_rows_q <= pwdata[nnr_pkg::DST_W-1:0];
				nnr_pkg::REG_DST_COLS: dst_cols_q <= pwdata[nnr_pkg::DST_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			nnr_pkg::REG_SRC_ROWS: prdata = nnr_pkg::APB_DW'(src_rows_q);
			nnr_pkg::REG_SRC_COLS: prdata = nnr_pkg::APB_DW'(src_cols_q);
			nnr_pkg::REG_CHANNELS: prdata = nnr_pkg::APB_DW'(channels_q);
			nnr_pkg::REG_DST_ROWS: prdata = nnr_pkg::APB_DW'(dst_rows_q);
			nnr_pkg::REG_DST_COLS: prdata = nnr_pkg::APB_DW'(dst_cols_q);
			default:               prdata = '0;
		endcase
	end

	// Effective sizes, held to their legal ranges.
	logic [nnr_pkg::SRC_W-1:0] sr;
	logic [nnr_pkg::SRC_W-1:0] sc;
	logic [nnr_pkg::CHN_W-1:0] nc;
	logic [nnr_pkg::DST_W-1:0] dr;
	logic [nnr_pkg::DST_W-1:0] dc;
	logic [nnr_pkg::SRC_W-1:0] sr_m1;
	logic [nnr_pkg::SRC_W-1:0] sc_m1;
	logic [nnr_pkg::DST_W-1:0] dr_m1;
	logic [nnr_pkg::DST_W-1:0] dc_m1;

	assign sr = nnr_pkg::SRC_W'(nnr_pkg::clamp_size(nnr_pkg::DST_W'(src_rows_q), MAX_ROWS));
	assign sc = nnr_pkg::SRC_W'(nnr_pkg::clamp_size(nnr_pkg::DST_W'(src_cols_q), MAX_COLS));
	assign nc = nnr_pkg::CHN_W'(nnr_pkg::clamp_size(nnr_pkg::DST_W'(channels_q), MAX_CHANNELS));
	assign dr = nnr_pkg::clamp_size(dst_rows_q, MAX_DST);
	assign dc = nnr_pkg::clamp_size(dst_cols_q, MAX_DST);
	assign sr_m1 = sr - nnr_pkg::SRC_W'(1);
	assign sc_m1 = sc - nnr_pkg::SRC_W'(1);
	assign dr_m1 = dr - nnr_pkg::DST_W'(1);
	assign dc_m1 = dc - nnr_pkg::DST_W'(1);

	// ------------------------------------------------------------------
	// Request capture and range check
	// ------------------------------------------------------------------
	nnr_pkg::state_t state_q, state_d;

	logic                         kind_q;
	logic [nnr_pkg::COORD_W-1:0]  row_q;
	logic [nnr_pkg::COORD_W-1:0]  col_q;
	logic [nnr_pkg::CH_W-1:0]     ch_q;
	logic [nnr_pkg::PIX_W-1:0]    pix_q;
	logic                         err_q;
	logic                         err_now;
	logic                         wr_err;
	logic                         rd_err;
	logic                         req_take;
	logic                         err_load;

	assign wr_err = (row_q >= nnr_pkg::COORD_W'(sr)) || (col_q >= nnr_pkg::COORD_W'(sc))
		|| (nnr_pkg::CHN_W'(ch_q) >= nc);
	assign rd_err = (nnr_pkg::DST_W'(row_q) >= dr) || (nnr_pkg::DST_W'(col_q) >= dc)
		|| (nnr_pkg::CHN_W'(ch_q) >= nc);
	assign err_now = (kind_q == nnr_pkg::KIND_READ) ? rd_err : wr_err;

	always_ff @(posedge clk) begin
		if (req_take) begin
			kind_q <= req.kind;
			row_q  <= req.row;
			col_q  <= req.col;
			ch_q   <= req.channel;
			pix_q  <= req.pixel_in;
		end
		if (err_load) begin
			err_q <= err_now;
		end
	end

	// ------------------------------------------------------------------
	// Index mapping: round(o*(s-1)/(d-1)) with halves rounded up
	// ------------------------------------------------------------------
	logic [nnr_pkg::NUM_W-1:0] num_row;
	logic [nnr_pkg::NUM_W-1:0] num_col;
	logic [nnr_pkg::DEN_W-1:0] den_row;
	logic [nnr_pkg::DEN_W-1:0] den_col;
	logic [nnr_pkg::QUO_W-1:0] quo_row;
	logic [nnr_pkg::QUO_W-1:0] quo_col;
	logic                      row_busy;
	logic                      col_busy;
	logic                      div_start;

	assign num_row = ((nnr_pkg::NUM_W'(row_q) * nnr_pkg::NUM_W'(sr_m1)) << 1)
		+ nnr_pkg::NUM_W'(dr_m1);
	assign num_col = ((nnr_pkg::NUM_W'(col_q) * nnr_pkg::NUM_W'(sc_m1)) << 1)
		+ nnr_pkg::NUM_W'(dc_m1);
	assign den_row = {dr_m1, 1'b0};
	assign den_col = {dc_m1, 1'b0};

	nnr_div u_div_row (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_row),
		.den    (den_row),
		.quo    (quo_row),
		.busy   (row_busy)
	);

	nnr_div u_div_col (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_col),
		.den    (den_col),
		.quo    (quo_col),
		.busy   (col_busy)
	);

	// A destination of one row or column maps everything onto index zero;
	// the result is also kept inside the source frame.
	logic [nnr_pkg::SRC_W-1:0] map_row;
	logic [nnr_pkg::SRC_W-1:0] map_col;

	always_comb begin
		map_row = quo_row;
		map_col = quo_col;
		if (dr_m1 == '0) begin
			map_row = '0;
		end else if (quo_row >= sr) begin
			map_row = sr_m1;
		end
		if (dc_m1 == '0) begin
			map_col = '0;
		end else if (quo_col >= sc) begin
			map_col = sc_m1;
		end
	end

	// ------------------------------------------------------------------
	// Pixel store, single port, registered read data
	// ------------------------------------------------------------------
	logic [nnr_pkg::PIX_W-1:0] mem [DEPTH];
	logic [nnr_pkg::PIX_W-1:0] rdata_q;
	logic [AW-1:0]             wr_addr;
	logic [AW-1:0]             rd_addr;
	logic [AW-1:0]             mem_addr;
	logic                      mem_we;
	logic                      mem_re;

	assign wr_addr = AW'(row_q * ROW_STRIDE + col_q * MAX_CHANNELS + ch_q);
	assign rd_addr = AW'(map_row * ROW_STRIDE + map_col * MAX_CHANNELS + ch_q);
	assign mem_addr = mem_we ? wr_addr : rd_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= pix_q;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic                      rsp_valid_q;
	logic [nnr_pkg::PIX_W-1:0] pixel_out_q;
	logic                      status_q;
	logic                      out_free;
	logic                      out_load;

	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nnr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_take  = 1'b0;
		err_load  = 1'b0;
		div_start = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			nnr_pkg::ST_IDLE: begin
				req_take = req.valid;
				if (req.valid) begin
					state_d = nnr_pkg::ST_CHECK;
				end
			end
			nnr_pkg::ST_CHECK: begin
				err_load = 1'b1;
				if (kind_q == nnr_pkg::KIND_READ && !err_now) begin
					div_start = 1'b1;
					state_d   = nnr_pkg::ST_DIVIDE;
				end else begin
					mem_we  = (kind_q == nnr_pkg::KIND_WRITE) && !err_now;
					state_d = nnr_pkg::ST_DONE;
				end
			end
			nnr_pkg::ST_DIVIDE: begin
				if (!row_busy && !col_busy) begin
					mem_re  = 1'b1;
					state_d = nnr_pkg::ST_DONE;
				end
			end
			nnr_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = nnr_pkg::ST_IDLE;
				end
			end
			default: state_d = nnr_pkg::ST_IDLE;
		endcase
	end

	assign req.ready = (state_q == nnr_pkg::ST_IDLE);

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q    <= err_q ? nnr_pkg::STATUS_RANGE : nnr_pkg::STATUS_OK;
			pixel_out_q <= (!err_q && kind_q == nnr_pkg::KIND_READ) ? rdata_q : '0;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.pixel_out = pixel_out_q;
	assign rsp.status    = status_q;

endmodule

// File: hdl/nnr_checker.sv
// ----------------------------------------------------------------------------
// Nearest-neighbor resize port checker
// Concurrent checks on the request and response ports of the top level.
// ----------------------------------------------------------------------------
module nnr_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_ready,
	input  logic                       rsp_valid,
	input  logic                       rsp_ready,
	input  logic [nnr_pkg::PIX_W-1:0]  pixel_out,
	input  logic                       status
);

	// A stalled result beat stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its contents.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(pixel_out) && $stable(status))
		else $error("result beat changed while stalled");

	// Only one request is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// A range error never carries a sample.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> pixel_out == '0)
		else $error("error result carries a nonzero sample");

endmodule

bind nearest_neighbor_resize_top nnr_checker u_nnr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.pixel_out (rsp.pixel_out),
	.status    (rsp.status)
);
